/* sv/ftlp_pkg.sv */
package ftlp_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned FtlpMaxSizeLog2 = 10;
  localparam int unsigned FtlpValueWidth  = 32;

  // Configuration reset value
  localparam logic [3:0] SizeLog2Reset = 4'd10;

  // Stream payload widths
  localparam int unsigned InTdataW  = 128;
  localparam int unsigned InTuserW  = 2;
  localparam int unsigned OutTdataW = 40;

  // Operation codes
  localparam logic [1:0] KindInsert = 2'd0;
  localparam logic [1:0] KindLookup = 2'd1;
  localparam logic [1:0] KindSwap   = 2'd2;
  localparam logic [1:0] KindDelete = 2'd3;

  // Bucket occupancy codes
  localparam logic [1:0] OccEmpty   = 2'd0;
  localparam logic [1:0] OccElement = 2'd1;
  localparam logic [1:0] OccDeleted = 2'd2;

  // Result status codes
  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  // Bucket entry layout: occupancy, addresses, ports, then the value on top
  localparam int unsigned EntOccLsb   = 0;
  localparam int unsigned EntAddrLsb  = 2;
  localparam int unsigned EntPortsLsb = 66;
  localparam int unsigned EntValueLsb = 98;

  typedef struct packed {
    logic [31:0] new_value;
    logic [15:0] peer_port;
    logic [15:0] local_port;
    logic [31:0] peer_ip;
    logic [31:0] host_ip;
    logic [1:0]  kind;
  } ftlp_req_t;

  typedef struct packed {
    logic [31:0] found_value;
    logic [1:0]  status;
  } ftlp_result_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } ftlp_stat_t;

endpackage

/* sv/ftlp_mem.sv */
module ftlp_mem #(
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 130
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [2**AddrW];
  logic [DataW-1:0] rdata_q;

  // One write port, one registered read port; read data holds when not read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ftlp_probe.sv */
module ftlp_probe #(
  parameter int unsigned MAX_SIZE_LOG2 = ftlp_pkg::FtlpMaxSizeLog2,
  parameter int unsigned VALUE_WIDTH   = ftlp_pkg::FtlpValueWidth,
  parameter int unsigned LgW           = $clog2(MAX_SIZE_LOG2 + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [LgW-1:0]         lg_i,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  input  ftlp_pkg::ftlp_req_t    req_i,
  input  logic                   slot_free_i,
  output logic                   res_valid_o,
  output ftlp_pkg::ftlp_result_t res_o,
  output ftlp_pkg::ftlp_stat_t   stat_o
);
  import ftlp_pkg::*;

  localparam int unsigned AW = MAX_SIZE_LOG2;
  localparam int unsigned EW = EntValueLsb + VALUE_WIDTH;

  localparam logic [1:0] SClear = 2'd0;
  localparam logic [1:0] SIdle  = 2'd1;
  localparam logic [1:0] SProbe = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  ftlp_req_t     req_q, req_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] step_q, step_d;
  logic [AW-1:0] mask_q, mask_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  ftlp_mem #(
    .AddrW (AW),
    .DataW (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Start bucket: top lg bits of the folded key
  logic [31:0]   hash;
  logic [31:0]   hash_sh;
  logic [AW-1:0] start_idx;
  logic [AW:0]   one_sh;
  logic [AW:0]   mask_full;

  assign hash      = req_i.host_ip ^ req_i.peer_ip ^ {16'd0, req_i.local_port}
                     ^ {16'd0, req_i.peer_port};
  assign hash_sh   = hash >> (6'd32 - 6'(lg_i));
  assign start_idx = hash_sh[AW-1:0];
  assign one_sh    = (AW + 1)'(1) << lg_i;
  assign mask_full = one_sh - (AW + 1)'(1);

  // Decode the bucket just read
  logic [1:0]             occ;
  logic [63:0]            ent_addr;
  logic [31:0]            ent_ports;
  logic [VALUE_WIDTH-1:0] ent_value;
  logic                   same, is_ins, hit_ins, hit_elem, stop_empty, last, finish;
  logic [VALUE_WIDTH+31:0] nv_ext, fv_ext;
  logic [VALUE_WIDTH-1:0] new_val;

  assign occ       = mem_rdata[EntOccLsb +: 2];
  assign ent_addr  = mem_rdata[EntAddrLsb +: 64];
  assign ent_ports = mem_rdata[EntPortsLsb +: 32];
  assign ent_value = mem_rdata[EntValueLsb +: VALUE_WIDTH];

  assign same = (occ != OccEmpty) && (ent_addr == {req_q.host_ip, req_q.peer_ip})
                && (ent_ports == {req_q.local_port, req_q.peer_port});
  assign is_ins     = (req_q.kind == KindInsert);
  assign hit_ins    = is_ins && ((occ == OccEmpty) || ((occ == OccDeleted) && same));
  assign hit_elem   = !is_ins && (occ == OccElement) && same;
  assign stop_empty = !is_ins && (occ == OccEmpty);
  assign last       = (step_q == mask_q);
  assign finish     = hit_ins || hit_elem || stop_empty || last;

  assign nv_ext  = {{VALUE_WIDTH{1'b0}}, req_q.new_value};
  assign new_val = nv_ext[VALUE_WIDTH-1:0];
  assign fv_ext  = {32'd0, ent_value};

  // Sequencer: clear sweep, then probe one bucket per cycle
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    req_d       = req_q;
    idx_d       = idx_q;
    step_d      = step_q;
    mask_d      = mask_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = start_idx;
    res_valid_o = 1'b0;
    res_o       = '0;
    req_ready_o = 1'b0;

    case (state_q)
      SClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        mem_wdata[EntOccLsb +: 2] = OccEmpty;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d   = req_i;
          idx_d   = start_idx;
          step_d  = '0;
          mask_d  = mask_full[AW-1:0];
          mem_re  = 1'b1;
          state_d = SProbe;
        end
      end
      SProbe: begin
        if (!finish) begin
          // advance to the next bucket, wrapping at the size in use
          mem_re    = 1'b1;
          mem_raddr = (idx_q + 1'b1) & mask_q;
          idx_d     = (idx_q + 1'b1) & mask_q;
          step_d    = step_q + 1'b1;
        end else if (slot_free_i) begin
          res_valid_o = 1'b1;
          state_d     = SIdle;
          if (hit_ins || hit_elem) begin
            res_o.status = StDone;
          end else begin
            res_o.status = is_ins ? StFull : StNotFound;
          end
          if (hit_elem && ((req_q.kind == KindLookup) || (req_q.kind == KindSwap))) begin
            res_o.found_value = fv_ext[31:0];
          end
          // write back the modified bucket
          if (hit_ins) begin
            mem_we = 1'b1;
            mem_wdata[EntOccLsb +: 2]            = OccElement;
            mem_wdata[EntAddrLsb +: 64]          = {req_q.host_ip, req_q.peer_ip};
            mem_wdata[EntPortsLsb +: 32]         = {req_q.local_port, req_q.peer_port};
            mem_wdata[EntValueLsb +: VALUE_WIDTH] = new_val;
          end else if (hit_elem && (req_q.kind == KindSwap)) begin
            mem_we = 1'b1;
            mem_wdata[EntValueLsb +: VALUE_WIDTH] = new_val;
          end else if (hit_elem && (req_q.kind == KindDelete)) begin
            mem_we = 1'b1;
            mem_wdata[EntOccLsb +: 2] = OccDeleted;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    idx_q  <= idx_d;
    step_q <= step_d;
    mask_q <= mask_d;
  end

  assign stat_o.clearing = (state_q == SClear);
  assign stat_o.busy     = (state_q == SProbe);

endmodule

/* sv/flow_table_linear_probe_unit.sv */
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tuser: kind; tdata: host_ip, peer_ip, local_port, peer_port,
//                      new_value
// m_axis    out        tdata: status, found_value (zero filled to 40 bits)
// cfg       in         cfg_data_i: size_log2
//
// Each operation is accepted, then probed one bucket per cycle, bound by the
// single read port of the bucket memory. After reset a clearing pass empties
// every bucket; no beat is accepted on s_axis until it ends. The result
// register lets a new beat be accepted while a result waits on m_axis; a probe
// that finishes while the result register is still full holds until it drains.
module flow_table_linear_probe_unit #(
  parameter int unsigned MAX_SIZE_LOG2 = ftlp_pkg::FtlpMaxSizeLog2,
  parameter int unsigned VALUE_WIDTH   = ftlp_pkg::FtlpValueWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] host_ip, [63:32] peer_ip, [79:64] local_port, [95:80] peer_port,
  // [127:96] new_value
  input  logic [ftlp_pkg::InTdataW-1:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [ftlp_pkg::InTuserW-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] status, [33:2] found_value, [39:34] zero
  output logic [ftlp_pkg::OutTdataW-1:0] m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [3:0]                     cfg_data_i
);
  import ftlp_pkg::*;

  localparam int unsigned LgW = $clog2(MAX_SIZE_LOG2 + 1);

  // Size register, clamped to the supported range
  logic [3:0]     size_q;
  logic [LgW-1:0] lg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeLog2Reset;
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (size_q == 4'd0) begin
      lg = LgW'(1);
    end else if (32'(size_q) > MAX_SIZE_LOG2) begin
      lg = LgW'(MAX_SIZE_LOG2);
    end else begin
      lg = LgW'(size_q);
    end
  end

  // Unpack the input beat
  ftlp_req_t req;
  assign req.kind       = s_axis_tuser[1:0];
  assign req.host_ip    = s_axis_tdata[31:0];
  assign req.peer_ip    = s_axis_tdata[63:32];
  assign req.local_port = s_axis_tdata[79:64];
  assign req.peer_port  = s_axis_tdata[95:80];
  assign req.new_value  = s_axis_tdata[127:96];

  logic         slot_free, res_valid;
  ftlp_result_t res;
  ftlp_stat_t   stat;
  logic         out_valid_q;
  ftlp_result_t out_q;

  assign slot_free = !out_valid_q || m_axis_tready;

  ftlp_probe #(
    .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
    .VALUE_WIDTH   (VALUE_WIDTH),
    .LgW           (LgW)
  ) u_probe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lg_i        (lg),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .stat_o      (stat)
  );

  // Result register: load on a finished probe, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.found_value, out_q.status};

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !s_axis_tready)
    else $error("input beat offered acceptance during clearing pass");

  a_res_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || m_axis_tready))
    else $error("result overwrote a waiting output beat");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (stat.busy && !s_axis_tready))
    else $error("probe not started after accepted beat");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res.status == StDone || res.status == StNotFound ||
                   res.status == StFull))
    else $error("illegal result status");

  a_found_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status != StDone) |-> (res.found_value == 32'd0))
    else $error("failed operation returned a value");

endmodule
